### rtl/core/gh_pkg.sv
// Shared types and constants for the grayscale histogram block.
`timescale 1ns / 1ps
`default_nettype none

package gh_pkg;

    // Q16 luminance weights (0.3, 0.59, 0.11); they sum to 65536
    localparam logic [15:0] W_RED   = 16'd19661;
    localparam logic [15:0] W_GREEN = 16'd38666;
    localparam logic [15:0] W_BLUE  = 16'd7209;

    localparam int GRAY_W     = 24;
    localparam int COLOR_W    = 8;
    localparam int BINSEL_W   = 8;
    localparam int NBINS_W    = 9;
    localparam int OUT_W      = 24;
    localparam int PROD_W     = GRAY_W + NBINS_W;

    localparam logic [NBINS_W-1:0] NUM_BINS_RESET = 9'd256;

    typedef enum logic
    {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } op_t;

endpackage

`default_nettype wire

### rtl/core/grayscale_histogram_top.sv
// Grayscale histogram: RGB-to-luminance binning with a read-and-clear counter store.
//
// Each accumulate transaction converts one RGB pixel to Q16 gray, maps it to bin
// floor(gray * num_bins / 2^24) (clamped to MAX_BINS-1) and increments that bin's
// counter, saturating at 2^COUNT_BITS-1. A read transaction returns the low 24 bits
// of one bin's count and clears that bin; reads past the store return 0. The pipeline
// takes one transaction per clock while pixel_stall is low: gray multiply, bin multiply,
// counter memory read, then modify and write back, with the write of the previous cycle
// forwarded into the next read of the same bin. Each result is held in an output register
// until taken. After reset the counter memory is cleared one entry per cycle, and
// pixel_stall stays high until that pass ends; num_bins writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module grayscale_histogram_top
    import gh_pkg::*;
#(
    parameter int MAX_BINS   = 256,
    parameter int COUNT_BITS = 24
)
(
    input  wire                 clk,
    input  wire                 rst_n,

    input  wire                 num_bins_we,
    input  wire [NBINS_W-1:0]   num_bins_wdata,

    input  wire                 pixel_valid,
    output logic                pixel_stall,
    input  wire                 operation,
    input  wire [COLOR_W-1:0]   red,
    input  wire [COLOR_W-1:0]   green,
    input  wire [COLOR_W-1:0]   blue,
    input  wire [BINSEL_W-1:0]  read_bin,

    output logic                result_valid,
    input  wire                 result_stall,
    output logic [OUT_W-1:0]    bin_count
);

    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(MAX_BINS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};

    // configuration
    logic [NBINS_W-1:0]    num_bins_reg;

    // clearing pass
    logic                  clearing_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;

    // pipeline
    logic                  advance;
    logic                  accept;
    logic [GRAY_W-1:0]     gray_s0;

    logic                  s1_valid_reg;
    op_t                   s1_op_reg;
    logic [GRAY_W-1:0]     s1_gray_reg;
    logic [BINSEL_W-1:0]   s1_idx_reg;

    logic [PROD_W-1:0]     bin_prod;
    logic [NBINS_W-1:0]    bin_raw;
    logic [ADDR_W-1:0]     s2_addr_next;
    logic                  s2_hit_next;

    logic                  s2_valid_reg;
    op_t                   s2_op_reg;
    logic [ADDR_W-1:0]     s2_addr_reg;
    logic                  s2_hit_reg;

    logic                  s3_valid_reg;
    op_t                   s3_op_reg;
    logic [ADDR_W-1:0]     s3_addr_reg;
    logic                  s3_hit_reg;

    // counter memory
    logic [COUNT_BITS-1:0] cnt_mem [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    // forwarding of the last item write
    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic                  fwd_hit;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  item_we;
    logic [COUNT_BITS-1:0] item_wdata;

    // output register
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_data_reg;

    assign advance     = !(out_valid_reg && result_stall);
    assign pixel_stall = clearing_reg || !advance;
    assign accept      = pixel_valid && !pixel_stall;

    assign gray_s0 = GRAY_W'(red)   * GRAY_W'(W_RED)
                   + GRAY_W'(green) * GRAY_W'(W_GREEN)
                   + GRAY_W'(blue)  * GRAY_W'(W_BLUE);

    assign bin_prod = PROD_W'(s1_gray_reg) * PROD_W'(num_bins_reg);
    assign bin_raw  = bin_prod[PROD_W-1:GRAY_W];

    always_comb
    begin
        if (s1_op_reg == OP_READ)
        begin
            s2_addr_next = ADDR_W'(s1_idx_reg);
            s2_hit_next  = (32'(s1_idx_reg) < 32'(MAX_BINS));
        end
        else
        begin
            s2_hit_next = 1'b1;
            if (32'(bin_raw) > 32'(MAX_BINS - 1))
                s2_addr_next = LAST_ADDR;
            else
                s2_addr_next = ADDR_W'(bin_raw);
        end
    end

    // the memory read issued last cycle missed the write made in that same cycle
    assign fwd_hit   = fwd_valid_reg && (fwd_addr_reg == s3_addr_reg);
    assign cur_count = fwd_hit ? fwd_data_reg : rd_data_reg;

    always_comb
    begin
        item_we = advance && s3_valid_reg && s3_hit_reg;
        if (s3_op_reg == OP_READ)
            item_wdata = '0;
        else if (cur_count == CNT_MAX)
            item_wdata = CNT_MAX;
        else
            item_wdata = cur_count + 1'b1;

        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = item_we;
            mem_waddr = s3_addr_reg;
            mem_wdata = item_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cnt_mem[mem_waddr] <= mem_wdata;
        if (advance)
            rd_data_reg <= cnt_mem[s2_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            num_bins_reg <= NUM_BINS_RESET;
        else if (num_bins_we)
            num_bins_reg <= num_bins_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                clearing_reg <= 1'b0;
            else
                clr_addr_reg <= ADDR_W'(clr_addr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fwd_valid_reg <= item_we && !clearing_reg;
            out_valid_reg <= s3_valid_reg && (s3_op_reg == OP_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg    <= op_t'(operation);
            s1_gray_reg  <= gray_s0;
            s1_idx_reg   <= read_bin;
            s2_op_reg    <= s1_op_reg;
            s2_addr_reg  <= s2_addr_next;
            s2_hit_reg   <= s2_hit_next;
            s3_op_reg    <= s2_op_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_hit_reg   <= s2_hit_reg;
            fwd_addr_reg <= s3_addr_reg;
            fwd_data_reg <= item_wdata;
            out_data_reg <= s3_hit_reg ? OUT_W'(cur_count) : '0;
        end
    end

    assign result_valid = out_valid_reg;
    assign bin_count    = out_data_reg;

    // no transaction may enter while the counter store is still being cleared
    a_no_item_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> !clearing_reg)
        else $error("transaction entered pipeline during clearing pass");

    // an accumulate always leaves a nonzero count behind
    a_accum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (item_we && s3_op_reg == OP_ACCUM) |-> (item_wdata != '0))
        else $error("accumulate wrote a zero count");

    // a saturated counter stays saturated
    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (item_we && s3_op_reg == OP_ACCUM && cur_count == CNT_MAX)
            |-> (item_wdata == CNT_MAX))
        else $error("counter wrapped past its maximum");

    // a read leaving stage three shows up as a result next cycle
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg && s3_op_reg == OP_READ) |=> out_valid_reg)
        else $error("read transaction produced no result");

    // a read past the store neither writes nor reports a count
    a_read_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s3_valid_reg && !s3_hit_reg) |=> (out_data_reg == '0))
        else $error("out-of-range read returned a nonzero count");

endmodule

`default_nettype wire
